// ----- hdl/psg_pkg.sv -----
package psg_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int PRIME_WIDTH = 32;
	localparam int COLS_WIDTH  = 8;
	localparam int LIMIT_WIDTH = 16;
	localparam int DATA_WIDTH  = 32;
	localparam int ADDR_WIDTH  = 3;
	localparam int CNT_WIDTH   = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

	localparam logic [VALUE_WIDTH-1:0] VALUE_MAX   = '1;
	localparam logic [VALUE_WIDTH-1:0] FIRST_PRIME = VALUE_WIDTH'(2);
	localparam logic [VALUE_WIDTH-1:0] SMALL_PRIME = VALUE_WIDTH'(3);
	localparam logic [VALUE_WIDTH-1:0] FIRST_TRIAL = VALUE_WIDTH'(5);
	localparam logic [VALUE_WIDTH-1:0] TRIAL_PAIR  = VALUE_WIDTH'(2);
	localparam logic [VALUE_WIDTH-1:0] TRIAL_STEP  = VALUE_WIDTH'(6);

	localparam logic [COLS_WIDTH-1:0]  COLUMNS_RESET = COLS_WIDTH'(10);
	localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET   = LIMIT_WIDTH'(100);

	// Register index, taken from paddr[2].
	localparam logic REG_COLUMNS     = 1'b0;
	localparam logic REG_PRIME_LIMIT = 1'b1;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// ----- hdl/psg_div.sv -----
module psg_div import psg_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [VALUE_WIDTH-1:0] divisor,
	output div_status_t            status,
	output logic [VALUE_WIDTH-1:0] quotient,
	output logic [VALUE_WIDTH-1:0] remainder
);

	logic                   busy_q;
	logic                   done_q;
	logic [CNT_WIDTH-1:0]   cnt_q;
	logic [VALUE_WIDTH-1:0] shift_q;
	logic [VALUE_WIDTH-1:0] rem_q;
	logic [VALUE_WIDTH-1:0] divisor_q;
	logic [VALUE_WIDTH:0]   trial;
	logic [VALUE_WIDTH:0]   diff;
	logic                   fits;

	// Restoring division, one quotient bit per cycle. The dividend bits leave
	// the top of shift_q while the quotient bits enter at the bottom.
	assign trial = {rem_q, shift_q[VALUE_WIDTH-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign fits  = !diff[VALUE_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_WIDTH'(VALUE_WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q   <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q   <= fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
			shift_q <= {shift_q[VALUE_WIDTH-2:0], fits};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = shift_q;
	assign remainder   = rem_q;

endmodule

// ----- hdl/psg_regs.sv -----
module psg_regs import psg_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ADDR_WIDTH-1:0]  paddr,
	input  logic [DATA_WIDTH-1:0]  pwdata,
	output logic [DATA_WIDTH-1:0]  prdata,
	output logic                   pready,
	output logic [COLS_WIDTH-1:0]  columns,
	output logic [LIMIT_WIDTH-1:0] prime_limit
);

	logic [COLS_WIDTH-1:0]  columns_q;
	logic [LIMIT_WIDTH-1:0] prime_limit_q;
	logic                   wr_en;
	logic                   reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q     <= COLUMNS_RESET;
			prime_limit_q <= LIMIT_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				REG_COLUMNS:     columns_q     <= pwdata[COLS_WIDTH-1:0];
				REG_PRIME_LIMIT: prime_limit_q <= pwdata[LIMIT_WIDTH-1:0];
				default:         columns_q     <= columns_q;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_COLUMNS:     prdata = DATA_WIDTH'(columns_q);
			REG_PRIME_LIMIT: prdata = DATA_WIDTH'(prime_limit_q);
			default:         prdata = '0;
		endcase
	end

	assign columns     = columns_q;
	assign prime_limit = prime_limit_q;

endmodule

// ----- hdl/prime_sequence_generator_core.sv -----
// Each request transaction returns the next prime in ascending order from 2, with an
// end-of-row mark every "columns" primes, a done flag once "prime_limit" primes have
// been given, and an overflow flag once the 32-bit range is used up; a request with
// restart set clears the sequence and returns all zeros. Primality is found by trial
// division through one bit-serial divider: each odd candidate gets a divide by 3 and
// then divides by 6k-1 and 6k+1 up to its square root. An even composite is skipped
// without a division, and any other composite stops at the trial divisor that divides it.
// Restart and done answers, and overflow answers once the range is already used up,
// go from ST_EVAL straight to ST_EMIT without a division. The block takes one request at
// a time; a finished result waits in the output register, and the next request may be
// accepted while it waits.
module prime_sequence_generator_core import psg_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   restart,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [PRIME_WIDTH-1:0] prime,
	output logic                   end_of_row,
	output logic                   done_res,
	output logic                   overflow,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ADDR_WIDTH-1:0]  paddr,
	input  logic [DATA_WIDTH-1:0]  pwdata,
	output logic [DATA_WIDTH-1:0]  prdata,
	output logic                   pready
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_CHECK,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		PH_THREE,
		PH_LOW,
		PH_HIGH
	} phase_t;

	typedef enum logic [1:0] {
		V_NONE,
		V_PRIME,
		V_COMPOSITE
	} verdict_t;

	state_t                 state_q;
	phase_t                 phase_q;
	phase_t                 next_phase;
	verdict_t               verdict;
	logic                   restart_q;
	logic [VALUE_WIDTH-1:0] cand_q;
	logic [LIMIT_WIDTH-1:0] given_q;
	logic [COLS_WIDTH-1:0]  col_q;
	logic                   exhausted_q;
	logic [VALUE_WIDTH-1:0] c_q;
	logic [VALUE_WIDTH-1:0] d_q;
	logic [VALUE_WIDTH-1:0] d_high;
	logic [VALUE_WIDTH-1:0] next_d;
	logic [VALUE_WIDTH-1:0] next_div;
	logic [VALUE_WIDTH-1:0] divisor_q;
	logic                   div_start_q;
	div_status_t            div_st;
	logic [VALUE_WIDTH-1:0] div_quot;
	logic [VALUE_WIDTH-1:0] div_rem;
	logic [COLS_WIDTH-1:0]  columns;
	logic [LIMIT_WIDTH-1:0] prime_limit;
	logic [COLS_WIDTH-1:0]  col_inc;
	logic                   decide;
	logic                   slot_free;
	logic                   emit;

	logic [PRIME_WIDTH-1:0] res_prime_q;
	logic                   res_eor_q;
	logic                   res_done_q;
	logic                   res_ovf_q;
	logic                   out_valid_q;
	logic [PRIME_WIDTH-1:0] out_prime_q;
	logic                   out_eor_q;
	logic                   out_done_q;
	logic                   out_ovf_q;

	psg_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.columns     (columns),
		.prime_limit (prime_limit)
	);

	psg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start_q),
		.dividend  (c_q),
		.divisor   (divisor_q),
		.status    (div_st),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign slot_free = !out_valid_q || !out_stall;
	assign emit      = (state_q == ST_EMIT) && slot_free;
	assign d_high    = d_q + TRIAL_PAIR;
	assign col_inc   = col_q + 1'b1;
	assign decide    = (state_q == ST_CHECK) || (state_q == ST_DIV && div_st.done);

	// Verdict on the current candidate, or the next trial divisor to try.
	always_comb begin
		verdict    = V_NONE;
		next_phase = phase_q;
		next_d     = d_q;
		next_div   = d_q;
		if (state_q == ST_CHECK) begin
			if (c_q < FIRST_PRIME) begin
				verdict = V_COMPOSITE;
			end else if (c_q <= SMALL_PRIME) begin
				verdict = V_PRIME;
			end else if (!c_q[0]) begin
				verdict = V_COMPOSITE;
			end else begin
				next_div   = SMALL_PRIME;
				next_phase = PH_THREE;
			end
		end else begin
			case (phase_q)
				PH_THREE: begin
					if (div_rem == '0) begin
						verdict = V_COMPOSITE;
					end else begin
						next_d     = FIRST_TRIAL;
						next_div   = FIRST_TRIAL;
						next_phase = PH_LOW;
					end
				end
				PH_LOW: begin
					// d > v / d is the same as d * d > v.
					if (d_q > div_quot) begin
						verdict = V_PRIME;
					end else if (div_rem == '0) begin
						verdict = V_COMPOSITE;
					end else begin
						next_div   = d_high;
						next_phase = PH_HIGH;
					end
				end
				PH_HIGH: begin
					if (d_high <= div_quot && div_rem == '0) begin
						verdict = V_COMPOSITE;
					end else begin
						next_d     = d_q + TRIAL_STEP;
						next_div   = d_q + TRIAL_STEP;
						next_phase = PH_LOW;
					end
				end
				default: verdict = V_NONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_THREE;
			restart_q   <= 1'b0;
			cand_q      <= FIRST_PRIME;
			given_q     <= '0;
			col_q       <= '0;
			exhausted_q <= 1'b0;
			c_q         <= '0;
			d_q         <= '0;
			divisor_q   <= '0;
			div_start_q <= 1'b0;
			res_prime_q <= '0;
			res_eor_q   <= 1'b0;
			res_done_q  <= 1'b0;
			res_ovf_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_prime_q <= '0;
			out_eor_q   <= 1'b0;
			out_done_q  <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (emit) begin
				out_valid_q <= 1'b1;
				out_prime_q <= res_prime_q;
				out_eor_q   <= res_eor_q;
				out_done_q  <= res_done_q;
				out_ovf_q   <= res_ovf_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						restart_q <= restart;
						state_q   <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					res_prime_q <= '0;
					res_eor_q   <= 1'b0;
					res_done_q  <= 1'b0;
					res_ovf_q   <= 1'b0;
					if (restart_q) begin
						cand_q      <= FIRST_PRIME;
						given_q     <= '0;
						col_q       <= '0;
						exhausted_q <= 1'b0;
						state_q     <= ST_EMIT;
					end else if (given_q >= prime_limit) begin
						res_done_q <= 1'b1;
						state_q    <= ST_EMIT;
					end else if (exhausted_q) begin
						res_ovf_q <= 1'b1;
						state_q   <= ST_EMIT;
					end else begin
						c_q     <= cand_q;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK, ST_DIV: begin
					if (decide) begin
						case (verdict)
							V_PRIME: begin
								if (c_q == VALUE_MAX) begin
									exhausted_q <= 1'b1;
								end else begin
									cand_q <= c_q + 1'b1;
								end
								given_q     <= given_q + 1'b1;
								res_prime_q <= PRIME_WIDTH'(c_q);
								if (col_inc >= columns) begin
									col_q     <= '0;
									res_eor_q <= 1'b1;
								end else begin
									col_q <= col_inc;
								end
								state_q <= ST_EMIT;
							end
							V_COMPOSITE: begin
								if (c_q == VALUE_MAX) begin
									exhausted_q <= 1'b1;
									res_ovf_q   <= 1'b1;
									state_q     <= ST_EMIT;
								end else begin
									c_q     <= c_q + 1'b1;
									state_q <= ST_CHECK;
								end
							end
							default: begin
								d_q         <= next_d;
								divisor_q   <= next_div;
								phase_q     <= next_phase;
								div_start_q <= 1'b1;
								state_q     <= ST_DIV;
							end
						endcase
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign prime      = out_prime_q;
	assign end_of_row = out_eor_q;
	assign done_res   = out_done_q;
	assign overflow   = out_ovf_q;

	// The divider is only started once the previous division has finished.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_start_q |-> !div_st.busy)
		else $error("divider started while busy");

	// An accepted request is evaluated in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_EVAL))
		else $error("accepted transaction not evaluated");

	// A result carries at most one of prime, done and overflow.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({(prime != '0) || end_of_row, done_res, overflow}))
		else $error("result carries conflicting flags");

	// A division result is only consumed while waiting on the divider.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> (state_q == ST_DIV))
		else $error("division finished outside of the divide state");

endmodule

// ----- verif/tb_prime_sequence_generator_core.sv -----
module tb_prime_sequence_generator_core;
	timeunit 1ns;
	timeprecision 1ps;

	import psg_pkg::*;

	localparam int WATCHDOG_LIMIT = 200000;
	localparam int MAX_REPORTS    = 10;

	typedef struct packed {
		logic [PRIME_WIDTH-1:0] prime;
		logic                   end_of_row;
		logic                   done_res;
		logic                   overflow;
	} prime_answer_t;

	// Tracks the sequence state of the block and the answers still owed by it.
	class prime_sequence_checker;
		logic [COLS_WIDTH-1:0]  columns;
		logic [LIMIT_WIDTH-1:0] prime_limit;
		longint unsigned        candidate;
		logic [LIMIT_WIDTH-1:0] primes_given;
		logic [COLS_WIDTH-1:0]  column_position;
		bit                     exhausted;
		prime_answer_t          owed_answers[$];
		int                     mismatches;
		int                     requests;
		int                     restarts;
		int                     primes_out;
		int                     row_ends;
		int                     done_out;
		int                     reg_writes;
		longint unsigned        top_prime;

		function new();
			columns     = COLUMNS_RESET;
			prime_limit = LIMIT_RESET;
			clear_sequence();
		endfunction

		function void clear_sequence();
			candidate       = 64'(FIRST_PRIME);
			primes_given    = '0;
			column_position = '0;
			exhausted       = 1'b0;
		endfunction

		static function bit is_prime(longint unsigned v);
			longint unsigned d;
			if (v < 2)
				return 1'b0;
			if (v <= 3)
				return 1'b1;
			if (v % 2 == 0 || v % 3 == 0)
				return 1'b0;
			for (d = 5; d * d <= v; d += 6) begin
				if (v % d == 0)
					return 1'b0;
				if ((d + 2) * (d + 2) <= v && v % (d + 2) == 0)
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function void write_reg(logic sel, logic [DATA_WIDTH-1:0] value);
			reg_writes++;
			if (sel == REG_COLUMNS)
				columns = value[COLS_WIDTH-1:0];
			else
				prime_limit = value[LIMIT_WIDTH-1:0];
		endfunction

		function void check_register(logic sel, logic [DATA_WIDTH-1:0] got);
			logic [DATA_WIDTH-1:0] want;
			want = (sel == REG_COLUMNS) ? DATA_WIDTH'(columns) : DATA_WIDTH'(prime_limit);
			if (got !== want) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("register %0d readback: expected %0d, got %0d", sel, want, got);
			end
		endfunction

		function void note_request(bit restart_req);
			prime_answer_t   ans;
			longint unsigned c;
			longint unsigned vmax;
			ans  = '0;
			vmax = 64'(VALUE_MAX);
			requests++;
			if (restart_req) begin
				restarts++;
				clear_sequence();
			end else if (primes_given >= prime_limit) begin
				done_out++;
				ans.done_res = 1'b1;
			end else if (exhausted || candidate > vmax) begin
				exhausted    = 1'b1;
				ans.overflow = 1'b1;
			end else begin
				c = candidate;
				while (!is_prime(c) && c < vmax)
					c++;
				if (!is_prime(c)) begin
					// No prime left up to the top of the value range.
					exhausted    = 1'b1;
					ans.overflow = 1'b1;
				end else begin
					if (c >= vmax)
						exhausted = 1'b1;
					else
						candidate = c + 1;
					primes_given    = primes_given + 1'b1;
					column_position = column_position + 1'b1;
					if (column_position >= columns) begin
						column_position = '0;
						ans.end_of_row  = 1'b1;
						row_ends++;
					end
					ans.prime = c[PRIME_WIDTH-1:0];
					primes_out++;
					if (c > top_prime)
						top_prime = c;
				end
			end
			owed_answers.push_back(ans);
		endfunction

		function void check_answer(prime_answer_t got);
			prime_answer_t want;
			if (owed_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("answer with no request outstanding: prime %0d eor %0b done %0b ovf %0b",
						got.prime, got.end_of_row, got.done_res, got.overflow);
				return;
			end
			want = owed_answers.pop_front();
			if (got.prime !== want.prime || got.end_of_row !== want.end_of_row ||
					got.done_res !== want.done_res || got.overflow !== want.overflow) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("answer mismatch: expected prime %0d eor %0b done %0b ovf %0b",
						want.prime, want.end_of_row, want.done_res, want.overflow);
					$display("                 got      prime %0d eor %0b done %0b ovf %0b",
						got.prime, got.end_of_row, got.done_res, got.overflow);
				end
			end
		endfunction

		function int pending();
			return owed_answers.size();
		endfunction
	endclass

	logic                   clk        = 1'b0;
	logic                   arst_n     = 1'b0;
	logic                   in_valid   = 1'b0;
	logic                   in_stall;
	logic                   restart    = 1'b0;
	logic                   out_valid;
	logic                   out_stall  = 1'b0;
	logic [PRIME_WIDTH-1:0] prime;
	logic                   end_of_row;
	logic                   done_res;
	logic                   overflow;
	logic                   psel       = 1'b0;
	logic                   penable    = 1'b0;
	logic                   pwrite     = 1'b0;
	logic [ADDR_WIDTH-1:0]  paddr      = '0;
	logic [DATA_WIDTH-1:0]  pwdata     = '0;
	logic [DATA_WIDTH-1:0]  prdata;
	logic                   pready;

	prime_sequence_checker prime_model = new();
	bit                    quiet_phase = 1'b0;
	int                    stall_left  = 0;
	int                    stuck_cycles = 0;

	prime_sequence_generator_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.prime      (prime),
		.end_of_row (end_of_row),
		.done_res   (done_res),
		.overflow   (overflow),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #4 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
		end else if (out_stall) begin
			out_stall  <= 1'b0;
			stall_left = $urandom_range(0, 6);
		end else if (!quiet_phase && $urandom_range(0, 2) == 0) begin
			out_stall  <= 1'b1;
			stall_left = gap_len();
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			prime_model.check_answer({prime, end_of_row, done_res, overflow});
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("No transaction for %0d cycles, %0d answers outstanding.",
				stuck_cycles, prime_model.pending());
			$display("tb_prime_sequence_generator_core failed");
			$finish;
		end
	end

	task automatic send_request(input bit restart_req);
		in_valid <= 1'b1;
		restart  <= restart_req;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		prime_model.note_request(restart_req);
	endtask

	task automatic pause_sender(input int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			restart  <= 1'($urandom_range(0, 1));
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic request(input bit restart_req);
		send_request(restart_req);
		pause_sender(quiet_phase ? 0 : gap_len());
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (prime_model.pending() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Write followed by a readback of the same register.
	task automatic write_reg(input logic sel, input logic [DATA_WIDTH-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		forever begin
			@(posedge clk);
			if (pready)
				break;
		end
		prime_model.write_reg(sel, value);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		forever begin
			@(posedge clk);
			if (pready)
				break;
		end
		prime_model.check_register(sel, prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int phase;
		int n;
		logic [DATA_WIDTH-1:0] cols;
		logic [DATA_WIDTH-1:0] lim;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: the tenth prime closes the first row.
		repeat (11) request(1'b0);
		// Dropping the row width below the current position ends the row at once.
		wait_idle();
		write_reg(REG_COLUMNS, 1);
		request(1'b0);
		request(1'b1);
		// Zero columns marks every prime; the limit then answers with done.
		wait_idle();
		write_reg(REG_COLUMNS, 0);
		write_reg(REG_PRIME_LIMIT, 2);
		repeat (3) request(1'b0);
		request(1'b1);
		wait_idle();
		write_reg(REG_PRIME_LIMIT, 0);
		request(1'b0);
		wait_idle();
		write_reg(REG_COLUMNS, 255);
		write_reg(REG_PRIME_LIMIT, 65535);
		repeat (2) request(1'b0);

		for (phase = 0; phase < 6; phase++) begin
			wait_idle();
			case (phase)
				0: begin
					cols = 1;
					lim  = 65535;
				end
				1: begin
					cols = 255;
					lim  = $urandom_range(20, 60);
				end
				2: begin
					cols = $urandom_range(2, 12);
					lim  = 1;
				end
				3: begin
					cols = $urandom_range(1, 255);
					lim  = $urandom_range(1, 10);
				end
				default: begin
					cols = $urandom_range(1, 16);
					lim  = ($urandom_range(0, 1) == 0) ? 65535 : $urandom_range(5, 80);
				end
			endcase
			quiet_phase = ($urandom_range(0, 3) == 0);
			write_reg(REG_COLUMNS, cols);
			write_reg(REG_PRIME_LIMIT, lim);
			for (n = 0; n < 45; n++) begin
				// Hold off new requests until the block has answered everything.
				if (n == 22 || $urandom_range(0, 59) == 0)
					wait_idle();
				request($urandom_range(0, 24) == 0);
			end
		end

		quiet_phase = 1'b0;
		wait_idle();
		repeat (20) @(posedge clk);

		$display("Sent %0d request transactions: %0d restarts, %0d primes up to %0d.",
			prime_model.requests, prime_model.restarts, prime_model.primes_out,
			prime_model.top_prime);
		$display("Saw %0d row ends and %0d done answers over %0d register writes.",
			prime_model.row_ends, prime_model.done_out, prime_model.reg_writes);
		if (prime_model.pending() != 0)
			$display("%0d answers never arrived.", prime_model.pending());
		if (prime_model.mismatches == 0 && prime_model.pending() == 0) begin
			$display("tb_prime_sequence_generator_core passed");
		end else begin
			$display("%0d mismatches.", prime_model.mismatches);
			$display("tb_prime_sequence_generator_core failed");
		end
		$finish;
	end

endmodule
